FILE: hw/rtl/sws_pkg.sv
// Shared types and codes for the shell word splitter.
// Used by sws_decode and shell_word_splitter_unit; no dependencies.
package sws_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef logic [1:0] kind_t;
    typedef logic [2:0] mode_t;

    localparam kind_t KIND_BYTE = 2'd0;
    localparam kind_t KIND_END  = 2'd1;
    localparam kind_t KIND_DONE = 2'd2;

    localparam mode_t MODE_UNQ     = 3'd0;
    localparam mode_t MODE_SQ      = 3'd1;
    localparam mode_t MODE_DQ      = 3'd2;
    localparam mode_t MODE_UNQ_ESC = 3'd3;
    localparam mode_t MODE_SQ_ESC  = 3'd4;
    localparam mode_t MODE_DQ_ESC  = 3'd5;
    localparam mode_t MODE_STOP    = 3'd6;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       qerr;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] slot;
        logic [CNT_W-1:0]          count;
        mode_t                     next_mode;
        logic                      next_open;
    } step_t;

endpackage

FILE: hw/rtl/sws_if.sv
// Valid/ready channel interfaces for the shell word splitter.
// Input request channel and result channel; no dependencies.
interface sws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_final;

    modport source (output valid, output char_in, output is_final, input ready);
    modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

interface sws_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] result_byte;
    logic       quote_error;
    logic       run_end;

    modport source (output valid, output result_kind, output result_byte,
                    output quote_error, output run_end, input ready);
    modport sink   (input valid, input result_kind, input result_byte,
                    input quote_error, input run_end, output ready);
endinterface

FILE: hw/rtl/sws_decode.sv
// Combinational decode of one byte against the scanner state.
// Depends on sws_pkg; produces up to four results and the next state.
module sws_decode (
    input  sws_pkg::mode_t mode,
    input  logic           word_open,
    input  logic [7:0]     char_in,
    input  logic           is_final,
    output sws_pkg::step_t step
);
    import sws_pkg::*;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LC_C   = 8'h63;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    logic [1:0] b_cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       mid_close;
    mode_t      mode_n;
    logic       open_n;
    logic       is_space;
    logic       in_dq;
    logic       qerr;

    assign is_space = (char_in == CH_SPACE) || (char_in == CH_HT) || (char_in == CH_LF) ||
                      (char_in == CH_CR) || (char_in == CH_VT) || (char_in == CH_FF);
    assign in_dq = (mode == MODE_DQ_ESC);

    always_comb
    begin
        b_cnt     = 2'd0;
        b0        = char_in;
        b1        = char_in;
        mid_close = 1'b0;
        mode_n    = mode;
        case (mode)
            MODE_UNQ:
            begin
                if (char_in == CH_SQUOTE)
                    mode_n = MODE_SQ;
                else if (char_in == CH_DQUOTE)
                    mode_n = MODE_DQ;
                else if (char_in == CH_BSLASH)
                begin
                    if (is_final)
                        b_cnt = 2'd1;
                    else
                        mode_n = MODE_UNQ_ESC;
                end
                else if (is_space)
                    mid_close = word_open;
                else if (char_in == CH_HASH && !word_open)
                    mode_n = MODE_STOP;
                else
                    b_cnt = 2'd1;
            end
            MODE_SQ:
            begin
                if (char_in == CH_BSLASH)
                begin
                    if (is_final)
                        b_cnt = 2'd1;
                    else
                        mode_n = MODE_SQ_ESC;
                end
                else if (char_in == CH_SQUOTE)
                    mode_n = MODE_UNQ;
                else
                    b_cnt = 2'd1;
            end
            MODE_DQ:
            begin
                if (char_in == CH_DQUOTE)
                    mode_n = MODE_UNQ;
                else if (char_in == CH_BSLASH)
                begin
                    if (is_final)
                        b_cnt = 2'd1;
                    else
                        mode_n = MODE_DQ_ESC;
                end
                else
                    b_cnt = 2'd1;
            end
            MODE_UNQ_ESC, MODE_DQ_ESC:
            begin
                mode_n = in_dq ? MODE_DQ : MODE_UNQ;
                b_cnt  = 2'd1;
                case (char_in)
                    CH_LC_C:
                    begin
                        if (in_dq)
                        begin
                            b_cnt = 2'd2;
                            b0    = CH_BSLASH;
                        end
                        else
                        begin
                            b_cnt  = 2'd0;
                            mode_n = MODE_STOP;
                        end
                    end
                    CH_LC_F: b0 = CH_FF;
                    CH_LC_N: b0 = CH_LF;
                    CH_LC_R: b0 = CH_CR;
                    CH_LC_T: b0 = CH_HT;
                    CH_LC_V: b0 = CH_VT;
                    CH_UNDER:
                    begin
                        if (in_dq)
                            b0 = CH_SPACE;
                        else
                        begin
                            b_cnt     = 2'd0;
                            mid_close = word_open;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_SQ_ESC:
            begin
                // only a quote or backslash is escaped; otherwise keep the backslash
                mode_n = MODE_SQ;
                b_cnt  = 2'd1;
                if (char_in != CH_SQUOTE && char_in != CH_BSLASH)
                begin
                    b_cnt = 2'd2;
                    b0    = CH_BSLASH;
                end
            end
            default: ;
        endcase
    end

    assign open_n = mid_close ? 1'b0 : ((b_cnt != 2'd0) ? 1'b1 : word_open);
    assign qerr = (mode_n == MODE_SQ) || (mode_n == MODE_DQ) ||
                  (mode_n == MODE_SQ_ESC) || (mode_n == MODE_DQ_ESC);

    always_comb
    begin
        logic [CNT_W-1:0] idx;
        step.slot = '0;
        idx       = '0;
        if (b_cnt != 2'd0)
        begin
            step.slot[0] = '{kind: KIND_BYTE, data: b0, qerr: 1'b0, last: 1'b0};
            if (b_cnt == 2'd2)
                step.slot[1] = '{kind: KIND_BYTE, data: b1, qerr: 1'b0, last: 1'b0};
            idx = CNT_W'(b_cnt);
        end
        if (mid_close)
        begin
            step.slot[idx[1:0]] = '{kind: KIND_END, data: 8'h00, qerr: 1'b0, last: 1'b0};
            idx = idx + 1'b1;
        end
        if (is_final)
        begin
            if (open_n)
            begin
                step.slot[idx[1:0]] = '{kind: KIND_END, data: 8'h00, qerr: 1'b0, last: 1'b0};
                idx = idx + 1'b1;
            end
            step.slot[idx[1:0]] = '{kind: KIND_DONE, data: 8'h00, qerr: qerr, last: 1'b0};
            idx = idx + 1'b1;
        end
        if (idx != '0)
            step.slot[2'(idx - 1'b1)].last = 1'b1;
        step.count     = idx;
        step.next_mode = is_final ? MODE_UNQ : mode_n;
        step.next_open = is_final ? 1'b0 : open_n;
    end

endmodule

FILE: hw/rtl/shell_word_splitter_unit.sv
// Shell word splitter: top level with input register, decode and result queue.
// Depends on sws_pkg, sws_if (sws_in_if, sws_out_if) and sws_decode.
//
// One byte request is taken per cycle unless the input register is stalled. A
// taken byte is held in the input register, decoded against the quote/escape
// state, and its zero to four results are pushed at once into a FIFO_DEPTH-entry
// result queue, which the result channel drains at one result per cycle while
// the consumer is ready. The input register advances only while the queue has
// room for four results, so sustained rate is one byte per cycle when the
// consumer is ready and bytes make one result each; bytes that make two to four
// results (escape pairs, word close at the end of a string, the done item) lower
// it. No clearing after reset.
module shell_word_splitter_unit #(
    parameter int FIFO_DEPTH = 8
) (
    input logic       clk,
    input logic       rst_n,
    sws_in_if.sink    char_chan,
    sws_out_if.source result_chan
);
    import sws_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_Q = $clog2(FIFO_DEPTH + 1);

    logic             in_vld_reg;
    logic [7:0]       char_reg;
    logic             fin_reg;
    mode_t            mode_reg;
    logic             word_open_reg;
    step_t            dec;
    logic             advance;
    logic             pop;
    logic [CNT_Q-1:0] push;
    logic [CNT_Q-1:0] count_reg;
    logic [CNT_Q-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    result_t          fifo_mem [FIFO_DEPTH];
    result_t          head;

    sws_decode u_decode (
        .mode      (mode_reg),
        .word_open (word_open_reg),
        .char_in   (char_reg),
        .is_final  (fin_reg),
        .step      (dec)
    );

    assign advance = in_vld_reg && (count_reg <= CNT_Q'(FIFO_DEPTH - MAX_RESULTS));
    assign char_chan.ready = !in_vld_reg || advance;
    assign pop = result_chan.valid && result_chan.ready;
    assign push = advance ? CNT_Q'(dec.count) : '0;
    assign count_next = count_reg + push - CNT_Q'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            mode_reg      <= MODE_UNQ;
            word_open_reg <= 1'b0;
            count_reg     <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
        end
        else
        begin
            if (char_chan.ready)
                in_vld_reg <= char_chan.valid;
            if (advance)
            begin
                mode_reg      <= dec.next_mode;
                word_open_reg <= dec.next_open;
            end
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
        begin
            char_reg <= char_chan.char_in;
            fin_reg  <= char_chan.is_final;
        end
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (advance && (CNT_W'(k) < dec.count))
                fifo_mem[wr_ptr_reg + PTR_W'(k)] <= dec.slot[k];
        end
    end

    assign head = fifo_mem[rd_ptr_reg];
    assign result_chan.valid       = (count_reg != '0);
    assign result_chan.result_kind = head.kind;
    assign result_chan.result_byte = head.data;
    assign result_chan.quote_error = head.qerr;
    assign result_chan.run_end     = head.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_Q'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fin_reg |=> (mode_reg == MODE_UNQ) && !word_open_reg)
        else $error("state not reset after final byte");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid && (result_chan.result_kind == KIND_DONE) |-> result_chan.run_end)
        else $error("done result not marked as last");

    a_qerr_done_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid && (result_chan.result_kind != KIND_DONE) |-> !result_chan.quote_error)
        else $error("quote error outside done result");

endmodule

FILE: tb/shell_word_splitter_unit_tb.sv
// Self-checking testbench for shell_word_splitter_unit: directed and random strings,
// predicted word bytes, word ends and done items checked in order via a scoreboard.
// Depends on sws_pkg, sws_if and the shell_word_splitter_unit RTL.
module shell_word_splitter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sws_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    class split_scoreboard;
        mode_t   mode;
        logic    word_open;
        result_t step_tokens[$];
        result_t expected_tokens[$];
        int      fail_count;

        function new();
            mode       = MODE_UNQ;
            word_open  = 1'b0;
            fail_count = 0;
        endfunction

        function void add_token(kind_t kind, logic [7:0] data, logic qerr);
            result_t tok;
            tok.kind = kind;
            tok.data = data;
            tok.qerr = qerr;
            tok.last = 1'b0;
            step_tokens = {step_tokens, tok};
        endfunction

        function void add_byte(logic [7:0] data);
            add_token(KIND_BYTE, data, 1'b0);
            word_open = 1'b1;
        endfunction

        function void close_word();
            if (word_open)
            begin
                add_token(KIND_END, 8'h00, 1'b0);
                word_open = 1'b0;
            end
        endfunction

        // 1: backslash-c outside double quotes, scan stops
        function bit escape_pair(logic [7:0] c, bit in_dq);
            case (c)
                CH_C:
                begin
                    if (!in_dq)
                        return 1'b1;
                    add_byte(CH_BSLASH);
                    add_byte(CH_C);
                end
                CH_F: add_byte(CH_FF);
                CH_N: add_byte(CH_LF);
                CH_R: add_byte(CH_CR);
                CH_T: add_byte(CH_HT);
                CH_V: add_byte(CH_VT);
                CH_UNDER:
                begin
                    if (in_dq)
                        add_byte(CH_SPACE);
                    else
                        close_word();
                end
                default: add_byte(c);
            endcase
            return 1'b0;
        endfunction

        function void single_quoted(logic [7:0] c, bit fin);
            if (c == CH_BSLASH)
            begin
                if (fin)
                    add_byte(CH_BSLASH);
                else
                    mode = MODE_SQ_ESC;
            end
            else if (c == CH_SQUOTE)
                mode = MODE_UNQ;
            else
                add_byte(c);
        endfunction

        function void predict_split(logic [7:0] c, bit fin);
            logic qerr;
            step_tokens.delete();
            case (mode)
                MODE_UNQ:
                begin
                    if (c == CH_SQUOTE)
                        mode = MODE_SQ;
                    else if (c == CH_DQUOTE)
                        mode = MODE_DQ;
                    else if (c == CH_BSLASH)
                    begin
                        if (fin)
                            add_byte(CH_BSLASH);
                        else
                            mode = MODE_UNQ_ESC;
                    end
                    else if (c == CH_SPACE || c == CH_HT || c == CH_LF ||
                             c == CH_CR || c == CH_VT || c == CH_FF)
                        close_word();
                    else if (c == CH_HASH && !word_open)
                        mode = MODE_STOP;
                    else
                        add_byte(c);
                end
                MODE_SQ: single_quoted(c, fin);
                MODE_DQ:
                begin
                    if (c == CH_DQUOTE)
                        mode = MODE_UNQ;
                    else if (c == CH_BSLASH)
                    begin
                        if (fin)
                            add_byte(CH_BSLASH);
                        else
                            mode = MODE_DQ_ESC;
                    end
                    else
                        add_byte(c);
                end
                MODE_UNQ_ESC: mode = escape_pair(c, 1'b0) ? MODE_STOP : MODE_UNQ;
                MODE_SQ_ESC:
                begin
                    mode = MODE_SQ;
                    if (c == CH_SQUOTE || c == CH_BSLASH)
                        add_byte(c);
                    else
                    begin
                        add_byte(CH_BSLASH);
                        single_quoted(c, fin);
                    end
                end
                MODE_DQ_ESC: mode = escape_pair(c, 1'b1) ? MODE_STOP : MODE_DQ;
                default: ;
            endcase
            if (fin)
            begin
                qerr = (mode == MODE_SQ || mode == MODE_DQ ||
                        mode == MODE_SQ_ESC || mode == MODE_DQ_ESC);
                close_word();
                add_token(KIND_DONE, 8'h00, qerr);
                mode      = MODE_UNQ;
                word_open = 1'b0;
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            expected_tokens = {expected_tokens, step_tokens};
        endfunction

        function void check_token(kind_t kind, logic [7:0] data, logic qerr, logic last);
            result_t want;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: result_kind %0d result_byte %02h", kind, data);
                fail_count++;
                return;
            end
            want = expected_tokens.pop_front();
            if (kind !== want.kind)
            begin
                $error("result_kind: expected %0d, actual %0d", want.kind, kind);
                fail_count++;
            end
            if (data !== want.data)
            begin
                $error("result_byte: expected %02h, actual %02h", want.data, data);
                fail_count++;
            end
            if (qerr !== want.qerr)
            begin
                $error("quote_error: expected %0b, actual %0b", want.qerr, qerr);
                fail_count++;
            end
            if (last !== want.last)
            begin
                $error("run_end: expected %0b, actual %0b", want.last, last);
                fail_count++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sws_in_if  char_chan ();
    sws_out_if result_chan ();

    split_scoreboard sb;
    int          sender_idle_pct = 20;
    int          recv_idle_pct   = 87;
    int unsigned sent_count      = 0;
    int          quiet_cycles    = 0;

    shell_word_splitter_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_chan   (char_chan),
        .result_chan (result_chan)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        result_chan.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_chan.valid && result_chan.ready)
            sb.check_token(result_chan.result_kind, result_chan.result_byte,
                           result_chan.quote_error, result_chan.run_end);
    end

    always @(posedge clk)
    begin
        if ((char_chan.valid && char_chan.ready) || (result_chan.valid && result_chan.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] c, input bit fin);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            char_chan.valid <= 1'b0;
            @(negedge clk);
        end
        char_chan.valid    <= 1'b1;
        char_chan.char_in  <= c;
        char_chan.is_final <= fin;
        @(posedge clk);
        while (!char_chan.ready)
            @(posedge clk);
        sb.predict_split(c, fin);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        int n;
        n = s.len();
        for (int i = 0; i < n; i++)
            send_char(s[i], i == n - 1);
    endtask

    function automatic logic [7:0] random_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return 8'h61 + 8'($urandom_range(25));
        if (roll < 35)
        begin
            case ($urandom_range(5))
                0: return CH_SPACE;
                1: return CH_HT;
                2: return CH_LF;
                3: return CH_CR;
                4: return CH_VT;
                default: return CH_FF;
            endcase
        end
        if (roll < 45)
            return CH_SQUOTE;
        if (roll < 55)
            return CH_DQUOTE;
        if (roll < 70)
            return CH_BSLASH;
        if (roll < 85)
        begin
            case ($urandom_range(6))
                0: return CH_C;
                1: return CH_F;
                2: return CH_N;
                3: return CH_R;
                4: return CH_T;
                5: return CH_V;
                default: return CH_UNDER;
            endcase
        end
        if (roll < 90)
            return CH_HASH;
        return 8'($urandom_range(255));
    endfunction

    task automatic random_strings(input int unsigned item_goal);
        int unsigned start;
        int unsigned len;
        start = sent_count;
        while (sent_count - start < item_goal)
        begin
            len = $urandom_range(1, 12);
            for (int unsigned i = 1; i <= len; i++)
                send_char(random_char(), i == len);
        end
    endtask

    task automatic drain_results();
        char_chan.valid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        char_chan.valid    = 1'b0;
        char_chan.char_in  = 8'h00;
        char_chan.is_final = 1'b0;
        result_chan.ready  = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // escapes in and out of quotes, mid-word hash, final backslash in open quotes
        send_string("a#\\f\\r\\v'\\\\\\'\\q'\"\\_\\c\\t\\");
        // extreme bytes, comment after a closed word
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_HASH, 1'b0);
        send_char(8'h78, 1'b1);
        // word break escape, backslash-c stop with an open word
        send_string("y\\_z\\c9");
        // lone final backslash
        send_string("\\");
        drain_results();

        random_strings(65);
        sender_idle_pct = 87;
        recv_idle_pct   = 20;
        random_strings(64);
        drain_results();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        random_strings(64);
        drain_results();

        if (sb.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/sws_pkg.sv
hw/rtl/sws_if.sv
hw/rtl/sws_decode.sv
hw/rtl/shell_word_splitter_unit.sv
tb/shell_word_splitter_unit_tb.sv
